FILE: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Coordinate types, register map codes and the control structs that pass
// between the top level, the vertex cells and the edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int COORD_W          = 16;
    localparam int RAY_EXTENSION    = 5000;
    localparam int CNT_W            = 5;
    localparam int IDX_W            = 4;
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 32;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_ray_x;
    typedef logic [2:0]                t_reg_idx;

    localparam t_reg_idx REG_BOUND_LEFT   = 3'd0;
    localparam t_reg_idx REG_BOUND_TOP    = 3'd1;
    localparam t_reg_idx REG_BOUND_RIGHT  = 3'd2;
    localparam t_reg_idx REG_BOUND_BOTTOM = 3'd3;
    localparam t_reg_idx REG_VERTEX_COUNT = 3'd4;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic clear;
        logic step;
    } t_edge_ctrl;

endpackage

FILE: rtl/pip_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cell: one vertex cell of the polygon ring
// Holds one vertex. Takes a new vertex on a load request and takes its
// neighbor's vertex on every shift cycle of a query.
// ----------------------------------------------------------------------------
module pip_cell (
    input  logic                i_clk,
    input  pip_pkg::t_cell_ctrl i_ctrl,
    input  pip_pkg::t_coord     i_load_x,
    input  pip_pkg::t_coord     i_load_y,
    input  pip_pkg::t_coord     i_shift_x,
    input  pip_pkg::t_coord     i_shift_y,
    output pip_pkg::t_coord     o_x,
    output pip_pkg::t_coord     o_y
);
    import pip_pkg::*;

    t_coord r_x;
    t_coord r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_ctrl.shift) begin
            r_x <= i_shift_x;
            r_y <= i_shift_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

FILE: rtl/pip_edge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_unit: ray/edge crossing test and parity accumulator
// Stage one forms the exact cross products for edge C->D against the ray
// P->R; stage two signs them and folds a crossing into the parity.
// ----------------------------------------------------------------------------
module pip_edge_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pip_pkg::t_edge_ctrl i_ctrl,
    input  pip_pkg::t_coord     i_px,
    input  pip_pkg::t_coord     i_py,
    input  pip_pkg::t_ray_x     i_rx,
    input  pip_pkg::t_coord     i_cx,
    input  pip_pkg::t_coord     i_cy,
    input  pip_pkg::t_coord     i_dx,
    input  pip_pkg::t_coord     i_dy,
    output logic                o_parity_next
);
    import pip_pkg::*;

    logic signed [16:0] w_dxc;
    logic signed [16:0] w_dyc;
    logic signed [16:0] w_pyc;
    logic signed [16:0] w_pxc;
    logic signed [17:0] w_rxc;
    logic signed [33:0] w_e;
    logic signed [33:0] w_f;
    logic signed [34:0] w_g;
    logic               w_s12;

    logic signed [33:0] r_e;
    logic signed [33:0] r_f;
    logic signed [34:0] r_g;
    logic               r_s12;
    logic               r_v;
    logic               r_parity;

    logic signed [35:0] w_d3;
    logic signed [35:0] w_d4;
    logic               w_cross;

    assign w_dxc = 17'(i_dx) - 17'(i_cx);
    assign w_dyc = 17'(i_dy) - 17'(i_cy);
    assign w_pyc = 17'(i_py) - 17'(i_cy);
    assign w_pxc = 17'(i_px) - 17'(i_cx);
    assign w_rxc = 18'(i_rx) - 18'(i_cx);

    assign w_e = 34'(w_dxc) * 34'(w_pyc);
    assign w_f = 34'(w_dyc) * 34'(w_pxc);
    assign w_g = 35'(w_dyc) * 35'(w_rxc);

    // ray runs to the right of P, so its own orientation test reduces to y
    assign w_s12 = (i_cy > i_py) != (i_dy > i_py);

    always_ff @(posedge i_clk) begin
        r_e   <= w_e;
        r_f   <= w_f;
        r_g   <= w_g;
        r_s12 <= w_s12;
    end

    assign w_d3    = 36'(r_e) - 36'(r_f);
    assign w_d4    = 36'(r_e) - 36'(r_g);
    assign w_cross = r_v && r_s12 && ((w_d3 > 36'sd0) != (w_d4 > 36'sd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_v <= i_ctrl.step;
            if (i_ctrl.clear) begin
                r_parity <= 1'b0;
            end else begin
                r_parity <= r_parity ^ w_cross;
            end
        end
    end

    assign o_parity_next = r_parity ^ w_cross;

endmodule

FILE: rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test: ray crossing parity test against a stored polygon
//
//   channel   handshake                       payload
//   request   start / busy                    i_action, i_vertex_index,
//                                             i_vertex_x/y, i_point_x/y
//   result    o_done (one-cycle strobe)       o_inside_res
//   config    psel/penable/pwrite/pready      paddr, pwdata, prdata
//
// A load request gives no result. A query that fails the rectangle test or
// has no vertices gives its result in the cycle after the request; otherwise
// the ring of n vertices (vertex count saturated to MAX_VERTICES) rotates
// once, one edge per cycle through the two-stage edge unit, and the result
// follows the drain state. busy is high while a query walks the ring. Reset
// is synchronous and clears the control and configuration registers; vertex
// cells and query point hold no reset value. The result cannot be stalled.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_action,
    input  logic [pip_pkg::IDX_W-1:0]  i_vertex_index,
    input  pip_pkg::t_coord            i_vertex_x,
    input  pip_pkg::t_coord            i_vertex_y,
    input  pip_pkg::t_coord            i_point_x,
    input  pip_pkg::t_coord            i_point_y,
    output logic                       o_done,
    output logic                       o_inside_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pip_pkg::ADDR_W-1:0] paddr,
    input  logic [pip_pkg::DATA_W-1:0] pwdata,
    output logic [pip_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import pip_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > CNT_W) ? NW : CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state           r_state;
    logic [IW-1:0]    r_step;
    logic [IW-1:0]    r_last;
    logic             r_done;
    logic             r_inside;

    t_coord           r_bound_left;
    t_coord           r_bound_top;
    t_coord           r_bound_right;
    t_coord           r_bound_bottom;
    logic [CNT_W-1:0] r_vertex_count;

    t_coord           r_px;
    t_coord           r_py;
    t_ray_x           r_rx;

    logic             w_accept;
    logic             w_load;
    logic             w_query;
    logic             w_cfg_wr;
    t_reg_idx         w_reg_idx;
    logic [CW-1:0]    w_cnt_ext;
    logic [NW-1:0]    w_n;
    logic [IW-1:0]    w_last;
    logic             w_in_rect;
    t_ray_x           w_rx;
    logic             w_parity_next;
    t_edge_ctrl       w_edge_ctrl;

    t_coord           w_cell_x [MAX_VERTICES];
    t_coord           w_cell_y [MAX_VERTICES];
    t_coord           w_next_x;
    t_coord           w_next_y;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_action == ACTION_LOAD);
    assign w_query  = w_accept && (i_action == ACTION_QUERY);

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_left   <= '0;
            r_bound_top    <= '0;
            r_bound_right  <= '0;
            r_bound_bottom <= '0;
            r_vertex_count <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_BOUND_LEFT:   r_bound_left   <= t_coord'(pwdata[COORD_W-1:0]);
                REG_BOUND_TOP:    r_bound_top    <= t_coord'(pwdata[COORD_W-1:0]);
                REG_BOUND_RIGHT:  r_bound_right  <= t_coord'(pwdata[COORD_W-1:0]);
                REG_BOUND_BOTTOM: r_bound_bottom <= t_coord'(pwdata[COORD_W-1:0]);
                REG_VERTEX_COUNT: r_vertex_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_BOUND_LEFT:   prdata = DATA_W'(r_bound_left);
            REG_BOUND_TOP:    prdata = DATA_W'(r_bound_top);
            REG_BOUND_RIGHT:  prdata = DATA_W'(r_bound_right);
            REG_BOUND_BOTTOM: prdata = DATA_W'(r_bound_bottom);
            REG_VERTEX_COUNT: prdata = DATA_W'(r_vertex_count);
            default:          prdata = '0;
        endcase
    end

    // ---------------- query setup ----------------
    assign w_cnt_ext = CW'(r_vertex_count);
    assign w_n       = (w_cnt_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                       : NW'(w_cnt_ext);
    assign w_last    = IW'(w_n - NW'(1));
    assign w_in_rect = (i_point_x >= r_bound_left) && (i_point_x < r_bound_right) &&
                       (i_point_y >= r_bound_top)  && (i_point_y < r_bound_bottom);
    assign w_rx      = t_ray_x'(r_bound_right) + t_ray_x'(RAY_EXTENSION);

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_rx <= w_rx;
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_last   <= '0;
            r_done   <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_query) begin
                        if ((w_n == '0) || !w_in_rect) begin
                            r_done   <= 1'b1;
                            r_inside <= 1'b0;
                        end else begin
                            r_state <= S_RUN;
                            r_step  <= '0;
                            r_last  <= w_last;
                        end
                    end
                end
                S_RUN: begin
                    r_step <= r_step + IW'(1);
                    if (r_step == r_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_done   <= 1'b1;
                    r_inside <= w_parity_next;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_inside_res = r_inside;

    // ---------------- vertex ring ----------------
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        t_cell_ctrl w_ctrl;
        t_coord     w_src_x;
        t_coord     w_src_y;

        assign w_ctrl.load  = w_load && (32'(i_vertex_index) == g);
        // cells past the last vertex in use hold their vertex
        assign w_ctrl.shift = (r_state == S_RUN) && (IW'(g) <= r_last);

        // close the ring at the last vertex in use
        if (g == MAX_VERTICES - 1) begin : g_tail
            assign w_src_x = w_cell_x[0];
            assign w_src_y = w_cell_y[0];
        end else begin : g_body
            assign w_src_x = (r_last == IW'(g)) ? w_cell_x[0] : w_cell_x[g+1];
            assign w_src_y = (r_last == IW'(g)) ? w_cell_y[0] : w_cell_y[g+1];
        end

        pip_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_load_x  (i_vertex_x),
            .i_load_y  (i_vertex_y),
            .i_shift_x (w_src_x),
            .i_shift_y (w_src_y),
            .o_x       (w_cell_x[g]),
            .o_y       (w_cell_y[g])
        );
    end

    // single-vertex polygon: the only edge is vertex 0 back to itself
    assign w_next_x = (r_last == '0) ? w_cell_x[0] : w_cell_x[1];
    assign w_next_y = (r_last == '0) ? w_cell_y[0] : w_cell_y[1];

    assign w_edge_ctrl.clear = w_query;
    assign w_edge_ctrl.step  = (r_state == S_RUN);

    pip_edge_unit u_edge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_edge_ctrl),
        .i_px          (r_px),
        .i_py          (r_py),
        .i_rx          (r_rx),
        .i_cx          (w_cell_x[0]),
        .i_cy          (w_cell_y[0]),
        .i_dx          (w_next_x),
        .i_dy          (w_next_y),
        .o_parity_next (w_parity_next)
    );

    // ---------------- checks ----------------
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACTION_LOAD)) |=> !o_done)
        else $error("load request produced a result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a query is still walking");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= r_last))
        else $error("edge counter ran past the last vertex");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (o_done && (r_state == S_IDLE)))
        else $error("drain did not deliver a result");

endmodule

FILE: sim/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test: self-checking bench for the point-in-polygon test
// Walks a short table of corner cases, then random phases that often reload the
// vertex ring, reprogram the bounding rectangle and vertex count over APB, and
// fire load and query requests. Each inside flag is predicted by an exact
// ray crossing count or pinned in the table, and compared against each o_done strobe.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test;
    import pip_pkg::*;

    localparam int MAX_VERTICES   = DEF_MAX_VERTICES;
    localparam int ITEM_TARGET    = 1100;
    localparam int QUIET_TAIL     = 150;
    localparam int SETTLE_CYCLES  = MAX_VERTICES + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PREDICT        = -1;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [3:0] sel;     // vertex index, or register index for ROW_REG
        t_coord     vx;      // register value for ROW_REG
        t_coord     vy;
        t_coord     px;
        t_coord     py;
        int         pinned;  // fixed inside flag, or PREDICT
    } t_stim_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               i_action       = ACTION_LOAD;
    logic [IDX_W-1:0]   i_vertex_index = '0;
    t_coord             i_vertex_x     = '0;
    t_coord             i_vertex_y     = '0;
    t_coord             i_point_x      = '0;
    t_coord             i_point_y      = '0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [ADDR_W-1:0]  paddr          = '0;
    logic [DATA_W-1:0]  pwdata         = '0;
    logic               busy;
    logic               o_done;
    logic               o_inside_res;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // predictor copy of the registers and the vertex ring
    t_coord             lim_left   = '0;
    t_coord             lim_top    = '0;
    t_coord             lim_right  = '0;
    t_coord             lim_bottom = '0;
    logic [CNT_W-1:0]   ring_count = '0;
    t_coord             ring_x [MAX_VERTICES];
    t_coord             ring_y [MAX_VERTICES];

    bit                 expected_inside [$];
    bit                 want_inside;
    t_stim_row          directed_rows [$];
    int                 pinned_result = PREDICT;
    int                 mismatches    = 0;
    int                 idle_cycles   = 0;
    int                 sent          = 0;
    bit                 gaps_on       = 1'b1;
    bit                 timed_out     = 1'b0;
    int                 zone_lo_x, zone_hi_x, zone_lo_y, zone_hi_y;

    point_in_polygon_test #(.MAX_VERTICES(MAX_VERTICES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_vertex_index(i_vertex_index),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .o_done(o_done), .o_inside_res(o_inside_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit turns_positive(input longint ax, input longint ay,
                                          input longint bx, input longint by,
                                          input longint qx, input longint qy);
        return ((bx - ax) * (qy - ay) - (by - ay) * (qx - ax)) > 0;
    endfunction

    function automatic bit ray_hits_edge(input longint px, input longint py,
                                         input longint rx,
                                         input longint ex0, input longint ey0,
                                         input longint ex1, input longint ey1);
        bit s1, s2, s3, s4;
        s1 = turns_positive(px, py, rx, py, ex0, ey0);
        s2 = turns_positive(px, py, rx, py, ex1, ey1);
        s3 = turns_positive(ex0, ey0, ex1, ey1, px, py);
        s4 = turns_positive(ex0, ey0, ex1, ey1, rx, py);
        return (s1 != s2) && (s3 != s4);
    endfunction

    function automatic bit point_inside(input t_coord px, input t_coord py);
        int     n, i, j, hits;
        longint rx;
        n    = (ring_count > MAX_VERTICES) ? MAX_VERTICES : int'(ring_count);
        hits = 0;
        if (n == 0)
            return 1'b0;
        if (px < lim_left || px >= lim_right || py < lim_top || py >= lim_bottom)
            return 1'b0;
        rx = longint'(lim_right) + RAY_EXTENSION;
        for (i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (ray_hits_edge(px, py, rx, ring_x[i], ring_y[i], ring_x[j], ring_y[j]))
                hits++;
        end
        return hits[0];
    endfunction

    function automatic int pick_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp16(input int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic void add_row(input t_row_kind kind, input int sel,
                                    input int vx, input int vy,
                                    input int px, input int py, input int pinned);
        t_stim_row r;
        r.kind   = kind;
        r.sel    = 4'(sel);
        r.vx     = t_coord'(vx);
        r.vy     = t_coord'(vy);
        r.px     = t_coord'(px);
        r.py     = t_coord'(py);
        r.pinned = pinned;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic t_stim_row zone_load(input int idx);
        t_stim_row r;
        r.kind   = ROW_LOAD;
        r.sel    = 4'(idx);
        r.px     = t_coord'($urandom);
        r.py     = t_coord'($urandom);
        r.pinned = PREDICT;
        if ($urandom_range(0, 4) == 0) begin
            r.vx = t_coord'($urandom);
            r.vy = t_coord'($urandom);
        end else begin
            r.vx = t_coord'(pick_between(zone_lo_x, zone_hi_x));
            r.vy = t_coord'(pick_between(zone_lo_y, zone_hi_y));
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic put_request(input t_stim_row r);
        if (gaps_on && sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat (pick_between(1, 17)) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= (r.kind == ROW_QUERY) ? ACTION_QUERY : ACTION_LOAD;
        i_vertex_index <= r.sel;
        i_vertex_x     <= r.vx;
        i_vertex_y     <= r.vy;
        i_point_x      <= r.px;
        i_point_y      <= r.py;
        pinned_result   = r.pinned;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx r, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop start, drain outstanding queries, then give a ring walk time to end
    task automatic settle_block();
        start <= 1'b0;
        while (expected_inside.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_stimulus();
        t_stim_row row;
        int        i, k, phase, len, mode, span, cx, cy, count;
        int        b_left, b_top, b_right, b_bottom;
        bit        reload;

        // empty polygon after reset
        add_row(ROW_QUERY, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 15, 32767, -32768, -32768, 32767, 0);
        add_row(ROW_REG, REG_BOUND_LEFT, -32768, 0, 0, 0, PREDICT);
        add_row(ROW_REG, REG_BOUND_TOP, -32768, 0, 0, 0, PREDICT);
        add_row(ROW_REG, REG_BOUND_RIGHT, 32767, 0, 0, 0, PREDICT);
        add_row(ROW_REG, REG_BOUND_BOTTOM, 32767, 0, 0, 0, PREDICT);
        add_row(ROW_LOAD, 0, -32768, -32768, 32767, -1, PREDICT);
        add_row(ROW_LOAD, 1, 32767, -32768, -32768, 32767, PREDICT);
        add_row(ROW_LOAD, 2, 32767, 32767, 0, 0, PREDICT);
        add_row(ROW_LOAD, 3, -32768, 32767, -1, -32768, PREDICT);
        add_row(ROW_REG, REG_VERTEX_COUNT, 4, 0, 0, 0, PREDICT);
        add_row(ROW_QUERY, 0, 0, 0, 0, 0, PREDICT);
        add_row(ROW_QUERY, 7, -1, -1, -32768, -32768, PREDICT);
        // right and bottom edges are exclusive
        add_row(ROW_QUERY, 0, 0, 0, 32767, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, 0, 32767, 0);
        add_row(ROW_QUERY, 0, 0, 0, 32766, 32766, PREDICT);
        add_row(ROW_QUERY, 0, 0, 0, -1, -1, PREDICT);
        add_row(ROW_REG, REG_VERTEX_COUNT, 3, 0, 0, 0, PREDICT);
        add_row(ROW_QUERY, 0, 0, 0, 100, -100, PREDICT);
        add_row(ROW_QUERY, 0, 0, 0, -100, 100, PREDICT);
        // collapsed rectangle rejects everything
        add_row(ROW_REG, REG_BOUND_RIGHT, -32768, 0, 0, 0, PREDICT);
        add_row(ROW_QUERY, 0, 0, 0, -32768, 0, 0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle_block();
                write_reg(t_reg_idx'(directed_rows[i].sel), int'(directed_rows[i].vx));
            end else begin
                put_request(directed_rows[i]);
            end
        end

        phase = 0;
        while (sent < ITEM_TARGET) begin
            settle_block();
            reload  = (phase == 0) || ($urandom_range(0, 9) < 7);
            gaps_on = ($urandom_range(0, 9) < 7);
            if (reload) begin
                case ($urandom_range(0, 3))
                    0: span = 40;
                    1: span = 600;
                    2: span = 8000;
                    default: span = 32767;
                endcase
                cx = pick_between(-32768, 32767);
                cy = pick_between(-32768, 32767);
                zone_lo_x = clamp16(cx - span);
                zone_hi_x = clamp16(cx + span);
                zone_lo_y = clamp16(cy - span);
                zone_hi_y = clamp16(cy + span);
            end

            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                b_left   = clamp16(zone_lo_x - pick_between(0, 50));
                b_right  = clamp16(zone_hi_x + pick_between(1, 50));
                b_top    = clamp16(zone_lo_y - pick_between(0, 50));
                b_bottom = clamp16(zone_hi_y + pick_between(1, 50));
            end else if (mode == 6) begin
                b_left   = -32768;
                b_top    = -32768;
                b_right  = 32767;
                b_bottom = 32767;
            end else if (mode < 9) begin
                // may come out inverted
                b_left   = pick_between(-32768, 32767);
                b_right  = pick_between(-32768, 32767);
                b_top    = pick_between(-32768, 32767);
                b_bottom = pick_between(-32768, 32767);
            end else begin
                b_left   = pick_between(-32768, 32767);
                b_right  = b_left;
                b_top    = pick_between(-32768, 32767);
                b_bottom = pick_between(-32768, 32767);
            end

            if (phase == 0)
                count = 31;
            else if (phase == 1)
                count = 0;
            else begin
                case ($urandom_range(0, 19))
                    0: count = 0;
                    1, 2: count = pick_between(17, 31);
                    3: count = MAX_VERTICES;
                    default: count = pick_between(1, MAX_VERTICES);
                endcase
            end

            write_reg(REG_BOUND_LEFT, b_left);
            write_reg(REG_BOUND_TOP, b_top);
            write_reg(REG_BOUND_RIGHT, b_right);
            write_reg(REG_BOUND_BOTTOM, b_bottom);
            write_reg(REG_VERTEX_COUNT, count);

            // every vertex is written in a reload phase, before that phase's queries
            if (reload) begin
                for (i = 0; i < MAX_VERTICES; i++)
                    put_request(zone_load(i));
            end

            len = pick_between(20, 60);
            for (i = 0; i < len && sent < ITEM_TARGET; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    row = zone_load(pick_between(0, MAX_VERTICES - 1));
                end else begin
                    row.kind   = ROW_QUERY;
                    row.sel    = 4'($urandom);
                    row.vx     = t_coord'($urandom);
                    row.vy     = t_coord'($urandom);
                    row.pinned = PREDICT;
                    k          = pick_between(0, MAX_VERTICES - 1);
                    mode       = $urandom_range(0, 9);
                    if (mode < 6) begin
                        if (lim_right > lim_left && lim_bottom > lim_top) begin
                            row.px = t_coord'(pick_between(lim_left, int'(lim_right) - 1));
                            row.py = t_coord'(pick_between(lim_top, int'(lim_bottom) - 1));
                        end else begin
                            row.px = t_coord'(pick_between(zone_lo_x, zone_hi_x));
                            row.py = t_coord'(pick_between(zone_lo_y, zone_hi_y));
                        end
                    end else if (mode == 6) begin
                        // ray through a vertex
                        row.px = t_coord'(pick_between(zone_lo_x, zone_hi_x));
                        row.py = ring_y[k];
                    end else if (mode == 7) begin
                        row.px = t_coord'(int'(ring_x[k]) + pick_between(-1, 1));
                        row.py = t_coord'(int'(ring_y[k]) + pick_between(-1, 1));
                    end else begin
                        row.px = t_coord'($urandom);
                        row.py = t_coord'($urandom);
                    end
                end
                put_request(row);
            end
            phase++;
        end
        settle_block();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done || (start && !busy) || (psel && penable && pwrite && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                if (expected_inside.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                             $time, o_inside_res);
                    mismatches++;
                end else begin
                    want_inside = expected_inside.pop_front();
                    if (o_inside_res !== want_inside) begin
                        $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                                 $time, want_inside, o_inside_res);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                if (i_action == ACTION_QUERY) begin
                    if (pinned_result == PREDICT)
                        expected_inside.insert(expected_inside.size(),
                                               point_inside(i_point_x, i_point_y));
                    else
                        expected_inside.insert(expected_inside.size(), pinned_result[0]);
                end else if (i_vertex_index < MAX_VERTICES) begin
                    ring_x[i_vertex_index] = i_vertex_x;
                    ring_y[i_vertex_index] = i_vertex_y;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_BOUND_LEFT:   lim_left   = t_coord'(pwdata[COORD_W-1:0]);
                    REG_BOUND_TOP:    lim_top    = t_coord'(pwdata[COORD_W-1:0]);
                    REG_BOUND_RIGHT:  lim_right  = t_coord'(pwdata[COORD_W-1:0]);
                    REG_BOUND_BOTTOM: lim_bottom = t_coord'(pwdata[COORD_W-1:0]);
                    REG_VERTEX_COUNT: ring_count = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            run_stimulus();
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out)
            $display("%0t: timeout, %0d results outstanding", $time, expected_inside.size());
        if (!timed_out && mismatches == 0)
            $display("point_in_polygon_test verification clean");
        else
            $display("point_in_polygon_test verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pip_pkg.sv
rtl/pip_cell.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_test.sv
sim/tb_point_in_polygon_test.sv
